// ===== rtl/imgs_pkg.sv =====
package imgs_pkg;

  localparam int NUM_VERTICES_DEF = 8;
  localparam int NUM_EDGES_DEF    = 16;

  localparam int CMD_W = 2;
  localparam int VTX_W = 4;
  localparam int EDG_W = 5;
  localparam int DEG_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADJACENT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEGREE   = 2'd2;

  localparam logic [DEG_W-1:0] DEGREE_MAX = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

// ===== rtl/imgs_col_ram.sv =====
module imgs_col_ram #(
  parameter int DEPTH = imgs_pkg::NUM_EDGES_DEF,
  parameter int WIDTH = imgs_pkg::NUM_VERTICES_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/incidence_matrix_graph_store_core.sv =====
// Vertex-by-edge incidence store. A command word is taken when start is high and busy is
// low. Insert and rejected commands answer in the cycle after acceptance and leave busy
// low. Adjacency and degree queries read one edge column per cycle from the column RAM,
// so they hold busy through ST_SCAN, which walks every edge column, and then ST_FIN,
// where the answer is formed and registered. Each result word appears for one cycle with
// out_valid high; the receiver cannot stall it and must take it then. Column occupancy
// is kept in per-column valid flops cleared by reset, so no clearing pass is needed.
module incidence_matrix_graph_store_core #(
  parameter int NUM_VERTICES = imgs_pkg::NUM_VERTICES_DEF,
  parameter int NUM_EDGES    = imgs_pkg::NUM_EDGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [imgs_pkg::CMD_W-1:0] in_command,
  input  logic [imgs_pkg::VTX_W-1:0] in_vertex_a,
  input  logic [imgs_pkg::VTX_W-1:0] in_vertex_b,
  input  logic [imgs_pkg::EDG_W-1:0] in_edge_index,
  output logic                       out_valid,
  output logic                       out_answer_flag,
  output logic [imgs_pkg::DEG_W-1:0] out_degree_count,
  output logic                       out_range_error
);

  localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int EW = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;

  imgs_pkg::state_t state_r, state_nxt;

  logic [NUM_EDGES-1:0]       vld_r, vld_nxt;
  logic [EW-1:0]              addr_r, addr_nxt;
  logic                       pend_r, pend_nxt;
  logic                       vq_r;
  logic [imgs_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [VW-1:0]              va_r, va_nxt;
  logic [VW-1:0]              vb_r, vb_nxt;
  logic                       flag_r, flag_nxt;
  logic [imgs_pkg::DEG_W-1:0] deg_r, deg_nxt;

  logic                       ov_r, ov_nxt;
  logic                       oflag_r, oflag_nxt;
  logic [imgs_pkg::DEG_W-1:0] odeg_r, odeg_nxt;
  logic                       oerr_r, oerr_nxt;

  logic                 wr_en;
  logic [EW-1:0]        wr_addr;
  logic [NUM_VERTICES-1:0] wr_data;
  logic                 rd_en;
  logic [NUM_VERTICES-1:0] rd_data;

  logic accept;
  logic va_bad, vb_bad, e_bad;
  logic [VW-1:0] in_va_idx, in_vb_idx;
  logic [EW-1:0] in_e_idx;
  logic ma, mb;

  imgs_col_ram #(
    .DEPTH (NUM_EDGES),
    .WIDTH (NUM_VERTICES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign busy   = (state_r != imgs_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign va_bad = ({1'b0, in_vertex_a} >= (imgs_pkg::VTX_W + 1)'(NUM_VERTICES));
  assign vb_bad = ({1'b0, in_vertex_b} >= (imgs_pkg::VTX_W + 1)'(NUM_VERTICES));
  assign e_bad  = ({1'b0, in_edge_index} >= (imgs_pkg::EDG_W + 1)'(NUM_EDGES));

  assign in_va_idx = in_vertex_a[VW-1:0];
  assign in_vb_idx = in_vertex_b[VW-1:0];
  assign in_e_idx  = in_edge_index[EW-1:0];

  assign wr_addr = in_e_idx;
  assign wr_data = (NUM_VERTICES'(1) << in_va_idx) | (NUM_VERTICES'(1) << in_vb_idx);

  // marks of the column read last cycle; unwritten columns read as empty
  assign ma = pend_r && vq_r && rd_data[va_r];
  assign mb = pend_r && vq_r && rd_data[vb_r];

  always_comb begin
    state_nxt = state_r;
    vld_nxt   = vld_r;
    addr_nxt  = addr_r;
    pend_nxt  = 1'b0;
    cmd_nxt   = cmd_r;
    va_nxt    = va_r;
    vb_nxt    = vb_r;
    flag_nxt  = flag_r;
    deg_nxt   = deg_r;
    ov_nxt    = 1'b0;
    oflag_nxt = 1'b0;
    odeg_nxt  = '0;
    oerr_nxt  = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;

    if (cmd_r == imgs_pkg::CMD_ADJACENT) begin
      flag_nxt = flag_r | (ma & mb);
    end else if (ma && (deg_r != imgs_pkg::DEGREE_MAX)) begin
      deg_nxt = deg_r + 1'b1;
    end

    unique case (state_r)
      imgs_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_command;
          va_nxt   = in_va_idx;
          vb_nxt   = in_vb_idx;
          flag_nxt = 1'b0;
          deg_nxt  = '0;
          addr_nxt = '0;
          unique case (in_command)
            imgs_pkg::CMD_INSERT: begin
              ov_nxt = 1'b1;
              if (va_bad || vb_bad || e_bad) begin
                oerr_nxt = 1'b1;
              end else if (!vld_r[in_e_idx]) begin
                wr_en             = 1'b1;
                vld_nxt[in_e_idx] = 1'b1;
                oflag_nxt         = 1'b1;
              end
            end
            imgs_pkg::CMD_ADJACENT: begin
              if (va_bad || vb_bad) begin
                ov_nxt   = 1'b1;
                oerr_nxt = 1'b1;
              end else begin
                state_nxt = imgs_pkg::ST_SCAN;
              end
            end
            imgs_pkg::CMD_DEGREE: begin
              if (va_bad) begin
                ov_nxt   = 1'b1;
                oerr_nxt = 1'b1;
              end else begin
                state_nxt = imgs_pkg::ST_SCAN;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      imgs_pkg::ST_SCAN: begin
        rd_en    = 1'b1;
        pend_nxt = 1'b1;
        if (addr_r == EW'(NUM_EDGES - 1)) begin
          state_nxt = imgs_pkg::ST_FIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      imgs_pkg::ST_FIN: begin
        state_nxt = imgs_pkg::ST_IDLE;
        ov_nxt    = 1'b1;
        if (cmd_r == imgs_pkg::CMD_ADJACENT) begin
          oflag_nxt = flag_nxt;
        end else begin
          odeg_nxt = deg_nxt;
        end
      end
      default: begin
        state_nxt = imgs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imgs_pkg::ST_IDLE;
      vld_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    vq_r    <= vld_r[addr_r];
    cmd_r   <= cmd_nxt;
    va_r    <= va_nxt;
    vb_r    <= vb_nxt;
    flag_r  <= flag_nxt;
    deg_r   <= deg_nxt;
    oflag_r <= oflag_nxt;
    odeg_r  <= odeg_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign out_valid        = ov_r;
  assign out_answer_flag  = oflag_r;
  assign out_degree_count = odeg_r;
  assign out_range_error  = oerr_r;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int NV = imgs_pkg::NUM_VERTICES_DEF;
  localparam int NE = imgs_pkg::NUM_EDGES_DEF;
  localparam int CW = imgs_pkg::CMD_W;
  localparam int VW = imgs_pkg::VTX_W;
  localparam int EW = imgs_pkg::EDG_W;
  localparam int DW = imgs_pkg::DEG_W;
  localparam int RANDOM_WORDS = 1300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 3 * (NE + 2);
  localparam logic [CW-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CW-1:0] command;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
    logic [EW-1:0] edge_idx;
  } cmd_word_t;

  typedef struct packed {
    logic          answer_flag;
    logic [DW-1:0] degree_count;
    logic          range_error;
  } answer_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [CW-1:0] in_command = '0;
  logic [VW-1:0] in_vertex_a = '0;
  logic [VW-1:0] in_vertex_b = '0;
  logic [EW-1:0] in_edge_index = '0;
  logic          busy;
  logic          out_valid;
  logic          out_answer_flag;
  logic [DW-1:0] out_degree_count;
  logic          out_range_error;

  cmd_word_t   pending_words[$];
  answer_t     expected_answers[$];
  int unsigned mark_count[NV][NE];
  cmd_word_t   cur_word;
  answer_t     want;
  int          idle_left = 0;
  int          launched = 0;
  int          accepted = 0;
  int          total_words = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  incidence_matrix_graph_store_core #(
    .NUM_VERTICES(NV),
    .NUM_EDGES(NE)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .in_edge_index   (in_edge_index),
    .out_valid       (out_valid),
    .out_answer_flag (out_answer_flag),
    .out_degree_count(out_degree_count),
    .out_range_error (out_range_error)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // applies one command word to the shadow matrix and returns its answer
  function automatic answer_t graph_apply(cmd_word_t w);
    answer_t r;
    bit      col_free;
    r = '0;
    unique case (w.command)
      imgs_pkg::CMD_INSERT: begin
        if (w.vertex_a >= NV || w.vertex_b >= NV || w.edge_idx >= NE) begin
          r.range_error = 1'b1;
        end else begin
          col_free = 1'b1;
          for (int v = 0; v < NV; v++) begin
            if (mark_count[v][w.edge_idx] != 0) col_free = 1'b0;
          end
          if (col_free) begin
            mark_count[w.vertex_a][w.edge_idx]++;
            mark_count[w.vertex_b][w.edge_idx]++;
            r.answer_flag = 1'b1;
          end
        end
      end
      imgs_pkg::CMD_ADJACENT: begin
        if (w.vertex_a >= NV || w.vertex_b >= NV) begin
          r.range_error = 1'b1;
        end else begin
          for (int e = 0; e < NE; e++) begin
            if (mark_count[w.vertex_a][e] != 0 && mark_count[w.vertex_b][e] != 0) begin
              r.answer_flag = 1'b1;
            end
          end
        end
      end
      imgs_pkg::CMD_DEGREE: begin
        if (w.vertex_a >= NV) begin
          r.range_error = 1'b1;
        end else begin
          for (int e = 0; e < NE; e++) begin
            if (mark_count[w.vertex_a][e] != 0 &&
                r.degree_count < imgs_pkg::DEGREE_MAX) begin
              r.degree_count = r.degree_count + 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void add_word(logic [CW-1:0] c, int a, int b, int e);
    cmd_word_t w;
    w.command  = c;
    w.vertex_a = VW'(a);
    w.vertex_b = VW'(b);
    w.edge_idx = EW'(e);
    pending_words.push_back(w);
  endfunction

  // driver: gap after each word is drawn at launch; every 160 words, 40 go back to back
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_answers.push_back(graph_apply(cur_word));
        accepted++;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_command <= cur_word.command;
          in_vertex_a <= cur_word.vertex_a;
          in_vertex_b <= cur_word.vertex_b;
          in_edge_index <= cur_word.edge_idx;
          start <= 1'b1;
          idle_left <= ((launched % 160) < 40) ? 0 : int'($urandom_range(0, 8));
          launched <= launched + 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_answers.pop_front();
        if (out_answer_flag !== want.answer_flag) begin
          report_mismatch($sformatf("answer_flag %b, want %b", out_answer_flag,
                                    want.answer_flag));
        end
        if (out_degree_count !== want.degree_count) begin
          report_mismatch($sformatf("degree_count %0d, want %0d", out_degree_count,
                                    want.degree_count));
        end
        if (out_range_error !== want.range_error) begin
          report_mismatch($sformatf("range_error %b, want %b", out_range_error,
                                    want.range_error));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[incidence_matrix_graph_store_core] ERROR");
      $finish;
    end
  end

  initial begin
    cmd_word_t w;
    int        sel;
    for (int v = 0; v < NV; v++) begin
      for (int e = 0; e < NE; e++) mark_count[v][e] = 0;
    end

    add_word(imgs_pkg::CMD_DEGREE, 5, 0, 0);
    add_word(imgs_pkg::CMD_ADJACENT, 2, 2, 0);
    add_word(imgs_pkg::CMD_INSERT, 0, 1, 0);
    add_word(imgs_pkg::CMD_INSERT, 3, 3, NE - 1);
    add_word(imgs_pkg::CMD_INSERT, 2, 4, 0);
    add_word(imgs_pkg::CMD_INSERT, NV - 1, 0, 1);
    add_word(imgs_pkg::CMD_INSERT, NV, 0, 2);
    add_word(imgs_pkg::CMD_INSERT, 0, 15, 2);
    add_word(imgs_pkg::CMD_INSERT, 1, 2, NE);
    add_word(imgs_pkg::CMD_INSERT, 1, 2, 31);
    add_word(imgs_pkg::CMD_ADJACENT, 0, 1, 31);
    add_word(imgs_pkg::CMD_ADJACENT, 1, 0, 0);
    add_word(imgs_pkg::CMD_ADJACENT, 3, 3, 0);
    add_word(imgs_pkg::CMD_ADJACENT, 0, 3, 0);
    add_word(imgs_pkg::CMD_ADJACENT, NV - 1, 0, 0);
    add_word(imgs_pkg::CMD_ADJACENT, NV, 1, 0);
    add_word(imgs_pkg::CMD_ADJACENT, 0, 15, 0);
    add_word(imgs_pkg::CMD_DEGREE, 0, 15, 31);
    add_word(imgs_pkg::CMD_DEGREE, 3, 0, 0);
    add_word(imgs_pkg::CMD_DEGREE, 15, 0, 0);
    add_word(imgs_pkg::CMD_DEGREE, NV, 0, 0);
    add_word(CMD_UNUSED, 15, 15, 31);
    add_word(CMD_UNUSED, 0, 0, 0);
    add_word(imgs_pkg::CMD_INSERT, 6, 5, 2);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      sel = $urandom_range(0, 99);
      w.command  = (sel < 35) ? imgs_pkg::CMD_INSERT : (sel < 65) ? imgs_pkg::CMD_ADJACENT :
                   (sel < 95) ? imgs_pkg::CMD_DEGREE : CMD_UNUSED;
      w.vertex_a = ($urandom_range(0, 9) < 8) ? VW'($urandom_range(0, NV - 1)) :
                                                VW'($urandom_range(0, 15));
      w.vertex_b = ($urandom_range(0, 9) < 8) ? VW'($urandom_range(0, NV - 1)) :
                                                VW'($urandom_range(0, 15));
      w.edge_idx = ($urandom_range(0, 9) < 8) ? EW'($urandom_range(0, NE - 1)) :
                                                EW'($urandom_range(0, 31));
      pending_words.push_back(w);
    end
    total_words = pending_words.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (accepted < total_words || expected_answers.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_answers.size() != 0) begin
      report_mismatch("expected result words never arrived");
    end
    if (error_count == 0) begin
      $display("[incidence_matrix_graph_store_core] OK");
    end else begin
      $display("[incidence_matrix_graph_store_core] ERROR");
    end
    $finish;
  end

endmodule
